@@ rtl/logic_analyzer_capture_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the logic analyzer capture core
// Shared property forms; each expects clk and arst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef LOGIC_ANALYZER_CAPTURE_CORE_ASSERT_SVH
`define LOGIC_ANALYZER_CAPTURE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LACAP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LACAP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lacap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacap_pkg
// Types and fixed constants of the logic analyzer capture core.
// ----------------------------------------------------------------------------
package lacap_pkg;

	localparam int LEVELS_W    = 8;
	localparam int IDX_W       = 11;
	localparam int PERIOD_W    = 32;
	localparam int TIMEOUT_W   = 32;
	localparam int DEPTH_REG_W = 12;
	localparam int CHCNT_W     = 4;
	localparam int MODE_W      = 2;
	localparam int TRIG_CH_W   = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DEPTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_CHANNEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TIMEOUT = 3'd5;

	// Trigger modes
	localparam logic [MODE_W-1:0] TRIG_NONE    = 2'd0;
	localparam logic [MODE_W-1:0] TRIG_RISING  = 2'd1;
	localparam logic [MODE_W-1:0] TRIG_FALLING = 2'd2;

	// Reset values
	localparam logic [PERIOD_W-1:0]    RST_PERIOD  = 32'd240;
	localparam logic [DEPTH_REG_W-1:0] RST_DEPTH   = 12'd2048;
	localparam logic [CHCNT_W-1:0]     RST_CHCNT   = 4'd4;
	localparam logic [TIMEOUT_W-1:0]   RST_TIMEOUT = 32'd240000000;

	// Channel count used when the register holds zero
	localparam logic [CHCNT_W-1:0] DEFAULT_CHCNT = 4'd4;

	// Command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic [PERIOD_W-1:0]    period;     // zero already mapped to one
		logic [DEPTH_REG_W-1:0] depth;      // raw register
		logic [LEVELS_W-1:0]    chan_mask;
		logic [MODE_W-1:0]      trig_mode;
		logic [TRIG_CH_W-1:0]   trig_chan;
		logic [TIMEOUT_W-1:0]   timeout;
	} lacap_cfg_t;

	typedef struct packed {
		logic                cmd;
		logic [LEVELS_W-1:0] levels;
	} lacap_item_t;

	typedef struct packed {
		logic [LEVELS_W-1:0] value;
		logic [IDX_W-1:0]    index;
		logic                last;
	} lacap_result_t;

endpackage

@@ rtl/lacap_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacap_in_if
// Tick / start channel of the capture core.
// ----------------------------------------------------------------------------
interface lacap_in_if import lacap_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [LEVELS_W-1:0] channel_levels;

	modport source (output valid, output cmd, output channel_levels, input ready);
	modport sink   (input valid, input cmd, input channel_levels, output ready);
endinterface

@@ rtl/lacap_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacap_out_if
// Sample result channel of the capture core.
// ----------------------------------------------------------------------------
interface lacap_out_if import lacap_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LEVELS_W-1:0] sample_value;
	logic [IDX_W-1:0]    sample_index;
	logic                last_sample;

	modport source (output valid, output sample_value, output sample_index,
		output last_sample, input ready);
	modport sink   (input valid, input sample_value, input sample_index,
		input last_sample, output ready);
endinterface

@@ rtl/lacap_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacap_cfg_if
// Register write channel of the capture core.
// ----------------------------------------------------------------------------
interface lacap_cfg_if import lacap_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output idx, output data, input ready);
	modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ rtl/logic_analyzer_capture_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logic_analyzer_capture_core
// Edge-triggered capture engine: trigger wait, periodic sampling, packing.
// ----------------------------------------------------------------------------
// Usage:
//   ticks   - one beat per sampling tick (cmd tick) with the channel levels,
//             or a start beat (cmd start) that arms a new capture.
//   samples - one beat per captured sample: packed levels, index in the
//             capture and a flag on the final sample.
//   cfg     - register writes (period, depth, channel count, trigger mode,
//             trigger channel, timeout); always ready, write only while idle.
// Throughput is one ticks beat per cycle while samples does not stall. A beat
// lands in the input register, then is evaluated against the capture state
// in a single pass into the result register, which drives samples. The
// capture state registers update together with the result register.
// When samples stalls, the result register holds its beat and ticks takes
// one more beat only while the input register is empty; after that
// ticks.ready drops until the sink takes the held sample.
// Reset returns every register to its default, the capture to idle and
// both pipeline registers to empty.
// ----------------------------------------------------------------------------
module logic_analyzer_capture_core import lacap_pkg::*; #(
	parameter int MAX_DEPTH    = 2048,
	parameter int MAX_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	lacap_in_if.sink    ticks,
	lacap_out_if.source samples,
	lacap_cfg_if.sink   cfg
);

	lacap_cfg_t    cfg_eff;
	lacap_item_t   item_s1;
	logic          item_valid_s1;
	logic          advance;
	logic          res_valid_q;
	lacap_result_t res_q;

	// Register writes never stall.
	assign cfg.ready = 1'b1;

	lacap_cfg #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_idx  (cfg.idx),
		.wr_data (cfg.data),
		.cfg_eff (cfg_eff)
	);

	// Input register: take a beat whenever the stage is empty or draining.
	assign ticks.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (ticks.valid && ticks.ready) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// Payload carries no reset; capture it with each accepted beat.
	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			item_s1.cmd    <= ticks.cmd;
			item_s1.levels <= ticks.channel_levels;
		end
	end

	lacap_engine #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_eff       (cfg_eff),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.advance       (advance),
		.res_ready     (samples.ready),
		.res_valid_q   (res_valid_q),
		.res_q         (res_q)
	);

	// Drive the result register straight onto the samples channel.
	assign samples.valid        = res_valid_q;
	assign samples.sample_value = res_q.value;
	assign samples.sample_index = res_q.index;
	assign samples.last_sample  = res_q.last;

endmodule

@@ rtl/lacap_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacap_cfg
// Configuration registers and their effective values.
// ----------------------------------------------------------------------------
module lacap_cfg import lacap_pkg::*; #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_idx,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output lacap_cfg_t            cfg_eff
);

	logic [PERIOD_W-1:0]    period_q;
	logic [DEPTH_REG_W-1:0] depth_q;
	logic [CHCNT_W-1:0]     chcnt_q;
	logic [MODE_W-1:0]      mode_q;
	logic [TRIG_CH_W-1:0]   trig_chan_q;
	logic [TIMEOUT_W-1:0]   timeout_q;
	logic [CHCNT_W-1:0]     chcnt_dflt;
	logic [CHCNT_W-1:0]     chcnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= RST_PERIOD;
			depth_q     <= RST_DEPTH;
			chcnt_q     <= RST_CHCNT;
			mode_q      <= TRIG_NONE;
			trig_chan_q <= '0;
			timeout_q   <= RST_TIMEOUT;
		end else if (wr_en) begin
			case (wr_idx)
				REG_SAMPLE_PERIOD:   period_q    <= wr_data[PERIOD_W-1:0];
				REG_SAMPLE_DEPTH:    depth_q     <= wr_data[DEPTH_REG_W-1:0];
				REG_CHANNEL_COUNT:   chcnt_q     <= wr_data[CHCNT_W-1:0];
				REG_TRIGGER_MODE:    mode_q      <= wr_data[MODE_W-1:0];
				REG_TRIGGER_CHANNEL: trig_chan_q <= wr_data[TRIG_CH_W-1:0];
				REG_TRIGGER_TIMEOUT: timeout_q   <= wr_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero channels means the default; clamp to the channels built in.
	always_comb begin
		chcnt_dflt = (chcnt_q == '0) ? DEFAULT_CHCNT : chcnt_q;
		chcnt_eff  = (chcnt_dflt > CHCNT_W'(MAX_CHANNELS)) ? CHCNT_W'(MAX_CHANNELS)
			: chcnt_dflt;
		for (int i = 0; i < LEVELS_W; i++) begin
			cfg_eff.chan_mask[i] = (CHCNT_W'(i) < chcnt_eff);
		end
		cfg_eff.period    = (period_q == '0) ? PERIOD_W'(1) : period_q;
		cfg_eff.depth     = depth_q;
		cfg_eff.trig_mode = mode_q;
		cfg_eff.trig_chan = trig_chan_q;
		cfg_eff.timeout   = timeout_q;
	end

endmodule

@@ rtl/lacap_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacap_engine
// Trigger wait, sample timing and the registered result stage.
// ----------------------------------------------------------------------------
module lacap_engine import lacap_pkg::*; #(
	parameter int MAX_DEPTH = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lacap_cfg_t    cfg_eff,
	input  logic          item_valid_s1,
	input  lacap_item_t   item_s1,
	output logic          advance,
	input  logic          res_ready,
	output logic          res_valid_q,
	output lacap_result_t res_q
);

	localparam int ST_W  = $clog2(MAX_DEPTH + 1);
	localparam int CMP_W = (ST_W > DEPTH_REG_W) ? ST_W : DEPTH_REG_W;

	localparam logic [1:0] PH_IDLE       = 2'd0;
	localparam logic [1:0] PH_WAIT_LEAVE = 2'd1;
	localparam logic [1:0] PH_WAIT_EDGE  = 2'd2;
	localparam logic [1:0] PH_SAMPLING   = 2'd3;

	logic [1:0]           phase_q, phase_d;
	logic [TIMEOUT_W-1:0] tmo_cnt_q, tmo_cnt_d, tmo_inc;
	logic [PERIOD_W-1:0]  per_cnt_q, per_cnt_d, per_inc;
	logic [ST_W-1:0]      taken_q, taken_d;
	logic [CMP_W-1:0]     depth_w, depth_eff;
	logic [CMP_W:0]       taken_inc;
	logic                 trig_lvl, active_lvl, emit, last;
	lacap_result_t        res_d;

	assign advance = item_valid_s1 && (!res_valid_q || res_ready);

	always_comb begin
		depth_w    = CMP_W'(cfg_eff.depth);
		depth_eff  = (depth_w == '0 || depth_w > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH)
			: depth_w;
		taken_inc  = (CMP_W + 1)'(taken_q) + 1'b1;
		last       = (taken_inc >= (CMP_W + 1)'(depth_eff));
		trig_lvl   = item_s1.levels[cfg_eff.trig_chan];
		active_lvl = (cfg_eff.trig_mode != TRIG_FALLING);
		tmo_inc    = (tmo_cnt_q == '1) ? tmo_cnt_q : tmo_cnt_q + 1'b1;
		per_inc    = (per_cnt_q == '1) ? per_cnt_q : per_cnt_q + 1'b1;

		phase_d   = phase_q;
		tmo_cnt_d = tmo_cnt_q;
		per_cnt_d = per_cnt_q;
		taken_d   = taken_q;
		emit      = 1'b0;
		res_d.value = item_s1.levels & cfg_eff.chan_mask;
		res_d.index = IDX_W'(taken_q);
		res_d.last  = last;

		if (item_s1.cmd == CMD_START) begin
			tmo_cnt_d = '0;
			per_cnt_d = '0;
			taken_d   = '0;
			if (cfg_eff.trig_mode == TRIG_RISING || cfg_eff.trig_mode == TRIG_FALLING) begin
				phase_d = PH_WAIT_LEAVE;
			end else begin
				phase_d = PH_SAMPLING;
			end
		end else begin
			case (phase_q)
				PH_WAIT_LEAVE, PH_WAIT_EDGE: begin
					tmo_cnt_d = tmo_inc;
					if (tmo_inc >= cfg_eff.timeout) begin
						phase_d   = PH_SAMPLING;
						per_cnt_d = '0;
					end else if (phase_q == PH_WAIT_LEAVE) begin
						if (trig_lvl != active_lvl) phase_d = PH_WAIT_EDGE;
					end else if (trig_lvl == active_lvl) begin
						phase_d   = PH_SAMPLING;
						per_cnt_d = '0;
					end
				end
				PH_SAMPLING: begin
					if (per_inc < cfg_eff.period) begin
						per_cnt_d = per_inc;
					end else begin
						per_cnt_d = '0;
						emit      = 1'b1;
						taken_d   = ST_W'(taken_inc);
						if (last) phase_d = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tmo_cnt_q   <= '0;
			per_cnt_q   <= '0;
			taken_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			tmo_cnt_q   <= tmo_cnt_d;
			per_cnt_q   <= per_cnt_d;
			taken_q     <= taken_d;
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

endmodule

@@ rtl/lacap_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacap_checker
// Port-level checks of the capture core, bound to the top level.
// ----------------------------------------------------------------------------
`include "logic_analyzer_capture_core_assert.svh"

module lacap_checker import lacap_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [LEVELS_W-1:0] sample_value,
	input logic [IDX_W-1:0]    sample_index,
	input logic                last_sample
);

	// A held sample beat keeps its payload until taken.
	`LACAP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_value) && $stable(sample_index) && $stable(last_sample), "samples beat changed while stalled")

	// Ticks may only stall behind a stalled sample.
	`LACAP_ASSERT_IMP(a_in_stall_cause, !in_ready, out_valid && !out_ready, "ticks stalled without a stalled sample")

	// A fresh sample beat comes from a tick that passed straight from the input register into the result register.
	`LACAP_ASSERT_IMP(a_out_origin, $rose(out_valid), $past(in_valid && in_ready, 2), "sample beat without a tick two cycles before")

endmodule

bind logic_analyzer_capture_core lacap_checker u_lacap_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (ticks.valid),
	.in_ready     (ticks.ready),
	.out_valid    (samples.valid),
	.out_ready    (samples.ready),
	.sample_value (samples.sample_value),
	.sample_index (samples.sample_index),
	.last_sample  (samples.last_sample)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the logic analyzer capture core.
// A short table of directed beats and register writes covers the reset
// state, the trigger modes, timeouts, restarts and the register extremes.
// Randomized capture phases follow, each with its own register setting.
// The table or a local model predicts each sample, and the sample channel is
// compared beat by beat against it under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
	import lacap_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int PIPE_FLUSH    = 8;    // beats pass the input and result registers; pad the flush
	localparam int IDLE_LIMIT    = 400;  // cycles without any beat before giving up
	localparam int PHASES        = 12;
	localparam int PHASE_BEATS   = 60;
	localparam int CAP_MAX_DEPTH = 2048;
	localparam int CAP_MAX_CH    = 8;

	// Capture state of the local model
	typedef enum logic [1:0] {
		CAP_IDLE,
		CAP_LEAVE,
		CAP_EDGE,
		CAP_SAMPLE
	} cap_state_e;

	// Directed table: a row is a register write or a ticks beat
	typedef enum logic {
		ROW_REG,
		ROW_BEAT
	} row_kind_e;

	// How a beat row is checked: typed-in sample, no sample, or the model
	typedef enum logic [1:0] {
		EXP_NONE,
		EXP_SAMPLE,
		EXP_PREDICT
	} row_exp_e;

	typedef struct {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  ridx;
		logic [CFG_DATA_W-1:0] data;
		logic                  cmd;
		logic [LEVELS_W-1:0]   levels;
		row_exp_e              chk;
		lacap_result_t         want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lacap_in_if  ticks_if ();
	lacap_out_if samples_if ();
	lacap_cfg_if cfg_if ();

	logic_analyzer_capture_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ticks   (ticks_if),
		.samples (samples_if),
		.cfg     (cfg_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register copies of the model
	logic [PERIOD_W-1:0]    m_period;
	logic [DEPTH_REG_W-1:0] m_depth;
	logic [CHCNT_W-1:0]     m_chcnt;
	logic [MODE_W-1:0]      m_mode;
	logic [TRIG_CH_W-1:0]   m_tchan;
	logic [TIMEOUT_W-1:0]   m_timeout;

	// Capture state of the model
	cap_state_e    m_state;
	logic [31:0]   m_tcount;
	logic [31:0]   m_pcount;
	logic [16:0]   m_taken;

	lacap_result_t pending_samples[$];
	plan_row_t     plan[$];
	int            errors = 0;
	bit            src_steady  = 1'b0;
	bit            sink_steady = 1'b0;

	// Advance the capture model by one ticks beat; report the sample it yields.
	function automatic void capture_step(input logic cmd, input logic [LEVELS_W-1:0] lv,
		output logic hit, output lacap_result_t res);
		logic        lvl;
		logic        active;
		logic [31:0] per;
		int unsigned depth;
		int unsigned nch;
		logic [8:0]  mask;
		logic        last;
		hit = 1'b0;
		res = '0;
		if (cmd == CMD_START) begin
			// A start costs no time: clear the counters and rearm
			m_tcount = '0;
			m_pcount = '0;
			m_taken  = '0;
			if (m_mode == TRIG_RISING || m_mode == TRIG_FALLING) begin
				m_state = CAP_LEAVE;
			end else begin
				m_state = CAP_SAMPLE;
			end
		end else if (m_state == CAP_LEAVE || m_state == CAP_EDGE) begin
			lvl    = lv[m_tchan];
			active = (m_mode == TRIG_FALLING) ? 1'b0 : 1'b1;
			if (m_tcount != 32'hFFFF_FFFF) m_tcount = m_tcount + 32'd1;
			// Timeout wins over the level check on the same tick
			if (m_tcount >= m_timeout) begin
				m_state  = CAP_SAMPLE;
				m_pcount = '0;
			end else if (m_state == CAP_LEAVE) begin
				if (lvl != active) m_state = CAP_EDGE;
			end else if (lvl == active) begin
				m_state  = CAP_SAMPLE;
				m_pcount = '0;
			end
		end else if (m_state == CAP_SAMPLE) begin
			per   = (m_period == '0) ? 32'd1 : m_period;
			depth = (m_depth == '0 || m_depth > CAP_MAX_DEPTH) ? CAP_MAX_DEPTH : m_depth;
			nch   = (m_chcnt == '0) ? DEFAULT_CHCNT : m_chcnt;
			if (nch > CAP_MAX_CH) nch = CAP_MAX_CH;
			mask = (9'd1 << nch) - 9'd1;
			if (m_pcount != 32'hFFFF_FFFF) m_pcount = m_pcount + 32'd1;
			if (m_pcount >= per) begin
				m_pcount  = '0;
				last      = (int'(m_taken) + 1 >= int'(depth));
				res.value = lv & mask[LEVELS_W-1:0];
				res.index = m_taken[IDX_W-1:0];
				res.last  = last;
				hit       = 1'b1;
				m_taken   = m_taken + 17'd1;
				if (last) m_state = CAP_IDLE;
			end
		end
	endfunction

	function automatic void plan_reg(input logic [CFG_IDX_W-1:0] ridx,
		input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r.kind   = ROW_REG;
		r.ridx   = ridx;
		r.data   = data;
		r.cmd    = CMD_TICK;
		r.levels = '0;
		r.chk    = EXP_NONE;
		r.want   = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_beat(input logic cmd, input logic [LEVELS_W-1:0] lv,
		input row_exp_e chk, input logic [LEVELS_W-1:0] value = '0,
		input logic [IDX_W-1:0] index = '0, input logic last = 1'b0);
		plan_row_t r;
		r.kind       = ROW_BEAT;
		r.ridx       = '0;
		r.data       = '0;
		r.cmd        = cmd;
		r.levels     = lv;
		r.chk        = chk;
		r.want.value = value;
		r.want.index = index;
		r.want.last  = last;
		plan.push_back(r);
	endfunction

	// Fill the bits above a register's field with noise half of the time.
	function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
		input int width);
		logic [CFG_DATA_W-1:0] keep;
		keep = (CFG_DATA_W'(1) << width) - 1;
		if ($urandom_range(0, 1) == 0) return v;
		return (v & keep) | ($urandom & ~keep);
	endfunction

	function automatic int src_gap();
		return src_steady ? 0 : $urandom_range(0, 9);
	endfunction

	// Write one register and mirror it into the model.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
		input logic [CFG_DATA_W-1:0] wdata);
		cfg_if.valid <= 1'b1;
		cfg_if.idx   <= ridx;
		cfg_if.data  <= wdata;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
		case (ridx)
			REG_SAMPLE_PERIOD:   m_period  = wdata[PERIOD_W-1:0];
			REG_SAMPLE_DEPTH:    m_depth   = wdata[DEPTH_REG_W-1:0];
			REG_CHANNEL_COUNT:   m_chcnt   = wdata[CHCNT_W-1:0];
			REG_TRIGGER_MODE:    m_mode    = wdata[MODE_W-1:0];
			REG_TRIGGER_CHANNEL: m_tchan   = wdata[TRIG_CH_W-1:0];
			REG_TRIGGER_TIMEOUT: m_timeout = wdata[TIMEOUT_W-1:0];
			default: ;
		endcase
	endtask

	// Offer one ticks beat after a random gap, predict, and queue the sample.
	task automatic send_beat(input logic cmd, input logic [LEVELS_W-1:0] lv,
		input row_exp_e chk, input lacap_result_t want);
		int            gap;
		logic          hit;
		lacap_result_t res;
		gap = src_gap();
		if (gap != 0) begin
			ticks_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ticks_if.valid          <= 1'b1;
		ticks_if.cmd            <= cmd;
		ticks_if.channel_levels <= lv;
		@(posedge clk);
		while (!ticks_if.ready) @(posedge clk);
		// Beat taken at this edge; the model always advances
		capture_step(cmd, lv, hit, res);
		case (chk)
			EXP_SAMPLE:  pending_samples.push_back(want);
			EXP_PREDICT: if (hit) pending_samples.push_back(res);
			default: ;
		endcase
	endtask

	// Drop valid, let every expected sample arrive, then flush the pipeline.
	task automatic drain_pipe();
		ticks_if.valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (PIPE_FLUSH) @(posedge clk);
	endtask

	// Sample sink: random stalls after each beat, compare against the queue.
	initial begin
		int            stall;
		lacap_result_t exp;
		stall = 0;
		samples_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && samples_if.valid && samples_if.ready) begin
				if (pending_samples.size() == 0) begin
					$error("unexpected sample beat: value %0h index %0d last %0b",
						samples_if.sample_value, samples_if.sample_index,
						samples_if.last_sample);
					errors++;
				end else begin
					exp = pending_samples.pop_front();
					if (samples_if.sample_value !== exp.value) begin
						$error("sample_value: expected %0h, got %0h", exp.value,
							samples_if.sample_value);
						errors++;
					end
					if (samples_if.sample_index !== exp.index) begin
						$error("sample_index: expected %0d, got %0d", exp.index,
							samples_if.sample_index);
						errors++;
					end
					if (samples_if.last_sample !== exp.last) begin
						$error("last_sample: expected %0b, got %0b", exp.last,
							samples_if.last_sample);
						errors++;
					end
				end
				stall = sink_steady ? 0 : $urandom_range(0, 9);
			end else if (stall > 0) begin
				stall--;
			end
			samples_if.ready <= (stall == 0);
		end
	end

	// Watchdog: give up once no channel has moved a beat for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((ticks_if.valid && ticks_if.ready) || (samples_if.valid && samples_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		plan_row_t             row;
		lacap_result_t         none;
		logic [CFG_DATA_W-1:0] v_period;
		logic [CFG_DATA_W-1:0] v_depth;
		logic [CFG_DATA_W-1:0] v_chcnt;
		logic [CFG_DATA_W-1:0] v_mode;
		logic [CFG_DATA_W-1:0] v_tchan;
		logic [CFG_DATA_W-1:0] v_timeout;
		logic                  cmd;
		bit                    prev_reg;
		int                    sel;

		none = '0;
		prev_reg = 1'b0;

		// Hold every input at a known value through reset
		arst_n                  <= 1'b0;
		ticks_if.valid          <= 1'b0;
		ticks_if.cmd            <= CMD_TICK;
		ticks_if.channel_levels <= '0;
		cfg_if.valid            <= 1'b0;
		cfg_if.idx              <= REG_SAMPLE_PERIOD;
		cfg_if.data             <= '0;

		// Model comes out of reset with the register defaults
		m_period  = RST_PERIOD;
		m_depth   = RST_DEPTH;
		m_chcnt   = RST_CHCNT;
		m_mode    = TRIG_NONE;
		m_tchan   = '0;
		m_timeout = RST_TIMEOUT;
		m_state   = CAP_IDLE;
		m_tcount  = '0;
		m_pcount  = '0;
		m_taken   = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tick while idle after reset: nothing comes out
		plan_beat(CMD_TICK, 8'hFF, EXP_NONE);

		// No trigger, period one, depth three, channel count zero packs four
		plan_reg(REG_SAMPLE_PERIOD, 32'd1);
		plan_reg(REG_SAMPLE_DEPTH, 32'd3);
		plan_reg(REG_CHANNEL_COUNT, 32'd0);
		plan_beat(CMD_START, 8'hFF, EXP_NONE);
		plan_beat(CMD_TICK, 8'hFF, EXP_SAMPLE, 8'h0F, 11'd0, 1'b0);
		plan_beat(CMD_TICK, 8'hA5, EXP_SAMPLE, 8'h05, 11'd1, 1'b0);
		plan_beat(CMD_TICK, 8'h5A, EXP_SAMPLE, 8'h0A, 11'd2, 1'b1);
		plan_beat(CMD_TICK, 8'hFF, EXP_NONE);

		// Rising edge on the top channel, no timeout, zero period acts as one
		plan_reg(REG_SAMPLE_PERIOD, 32'd0);
		plan_reg(REG_SAMPLE_DEPTH, 32'd1);
		plan_reg(REG_CHANNEL_COUNT, 32'd8);
		plan_reg(REG_TRIGGER_MODE, {30'd0, TRIG_RISING});
		plan_reg(REG_TRIGGER_CHANNEL, 32'd7);
		plan_reg(REG_TRIGGER_TIMEOUT, 32'hFFFF_FFFF);
		plan_beat(CMD_START, 8'h00, EXP_NONE);
		plan_beat(CMD_TICK, 8'h80, EXP_NONE);
		plan_beat(CMD_TICK, 8'h00, EXP_NONE);
		plan_beat(CMD_TICK, 8'h80, EXP_NONE);
		plan_beat(CMD_TICK, 8'hFF, EXP_SAMPLE, 8'hFF, 11'd0, 1'b1);

		// Falling edge cut short by the timeout; oversized count and depth saturate
		plan_reg(REG_TRIGGER_MODE, {30'd0, TRIG_FALLING});
		plan_reg(REG_TRIGGER_CHANNEL, 32'd3);
		plan_reg(REG_CHANNEL_COUNT, 32'd15);
		plan_reg(REG_SAMPLE_DEPTH, 32'd4095);
		plan_reg(REG_SAMPLE_PERIOD, 32'd2);
		plan_reg(REG_TRIGGER_TIMEOUT, 32'd3);
		plan_beat(CMD_START, 8'hFF, EXP_NONE);
		plan_beat(CMD_TICK, 8'h00, EXP_NONE);
		plan_beat(CMD_TICK, 8'h08, EXP_NONE);
		plan_beat(CMD_TICK, 8'hFF, EXP_NONE);
		plan_beat(CMD_TICK, 8'h12, EXP_NONE);
		plan_beat(CMD_TICK, 8'h34, EXP_SAMPLE, 8'h34, 11'd0, 1'b0);
		// Restart in the middle of a capture
		plan_beat(CMD_START, 8'h00, EXP_PREDICT);
		plan_beat(CMD_TICK, 8'h00, EXP_PREDICT);

		// Unused trigger mode behaves as none
		plan_reg(REG_TRIGGER_MODE, 32'd3);
		plan_reg(REG_TRIGGER_TIMEOUT, 32'd0);
		plan_reg(REG_SAMPLE_PERIOD, 32'd1);
		plan_reg(REG_SAMPLE_DEPTH, 32'd2);
		plan_beat(CMD_START, 8'h00, EXP_NONE);
		plan_beat(CMD_TICK, 8'hF0, EXP_PREDICT);
		plan_beat(CMD_TICK, 8'h0F, EXP_PREDICT);

		// Zero timeout ends the trigger wait on the first tick
		plan_reg(REG_TRIGGER_MODE, {30'd0, TRIG_RISING});
		plan_beat(CMD_START, 8'h00, EXP_NONE);
		plan_beat(CMD_TICK, 8'hFF, EXP_NONE);
		plan_beat(CMD_TICK, 8'h3C, EXP_SAMPLE, 8'h3C, 11'd0, 1'b0);
		plan_beat(CMD_TICK, 8'hC3, EXP_SAMPLE, 8'hC3, 11'd1, 1'b1);

		// Walk the table; drain the pipeline before each group of writes
		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_REG) begin
				if (!prev_reg) drain_pipe();
				write_reg(row.ridx, row.data);
				prev_reg = 1'b1;
			end else begin
				send_beat(row.cmd, row.levels, row.chk, row.want);
				prev_reg = 1'b0;
			end
		end

		// Random phases, each with a fresh setting of every register
		for (int p = 0; p < PHASES; p++) begin
			drain_pipe();
			src_steady  = ($urandom_range(0, 2) == 0);
			sink_steady = ($urandom_range(0, 2) == 0);
			if (p == 0) begin
				// Top of every range: the capture never gets to sample
				v_period  = 32'hFFFF_FFFF;
				v_depth   = CAP_MAX_DEPTH;
				v_chcnt   = CAP_MAX_CH;
				v_mode    = {30'd0, TRIG_FALLING};
				v_tchan   = 32'd7;
				v_timeout = 32'hFFFF_FFFF;
			end else if (p == 1) begin
				// Bottom of every range
				v_period  = 32'd1;
				v_depth   = 32'd1;
				v_chcnt   = 32'd1;
				v_mode    = {30'd0, TRIG_NONE};
				v_tchan   = 32'd0;
				v_timeout = 32'd1;
			end else begin
				sel = $urandom_range(0, 9);
				case (sel)
					0:       v_period = 32'd0;
					1:       v_period = 32'hFFFF_FFFF;
					2:       v_period = $urandom;
					default: v_period = $urandom_range(1, 4);
				endcase
				sel = $urandom_range(0, 9);
				case (sel)
					0:       v_depth = 32'd0;
					1:       v_depth = $urandom_range(CAP_MAX_DEPTH, 4095);
					default: v_depth = $urandom_range(1, 8);
				endcase
				v_depth = with_junk(v_depth, DEPTH_REG_W);
				v_chcnt = with_junk($urandom_range(0, 15), CHCNT_W);
				v_mode  = with_junk($urandom_range(0, 3), MODE_W);
				v_tchan = with_junk($urandom_range(0, 7), TRIG_CH_W);
				sel = $urandom_range(0, 9);
				case (sel)
					0:       v_timeout = 32'd0;
					1:       v_timeout = 32'hFFFF_FFFF;
					2:       v_timeout = $urandom;
					default: v_timeout = $urandom_range(1, 16);
				endcase
			end
			write_reg(REG_SAMPLE_PERIOD, v_period);
			write_reg(REG_SAMPLE_DEPTH, v_depth);
			write_reg(REG_CHANNEL_COUNT, v_chcnt);
			write_reg(REG_TRIGGER_MODE, v_mode);
			write_reg(REG_TRIGGER_CHANNEL, v_tchan);
			write_reg(REG_TRIGGER_TIMEOUT, v_timeout);

			// Mostly open with a start; now and then leave the capture untouched
			if ($urandom_range(0, 5) != 0) begin
				send_beat(CMD_START, LEVELS_W'($urandom), EXP_PREDICT, none);
			end
			repeat (PHASE_BEATS) begin
				cmd = ($urandom_range(0, 39) == 0) ? CMD_START : CMD_TICK;
				send_beat(cmd, LEVELS_W'($urandom), EXP_PREDICT, none);
			end
		end

		// Let the last samples drain, then report
		drain_pipe();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lacap_pkg.sv
rtl/lacap_in_if.sv
rtl/lacap_out_if.sv
rtl/lacap_cfg_if.sv
rtl/lacap_cfg.sv
rtl/lacap_engine.sv
rtl/logic_analyzer_capture_core.sv
rtl/lacap_checker.sv
test/tb.sv
